@@ sv/mp2d_pkg.sv @@
package mp2d_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_WIDTH_DEF   = 1024;
  localparam int MAX_POOL_DEF    = 8;
  localparam int SAMPLE_BITS_DEF = 16;

  // Height limit and fixed field and register widths
  localparam int HEIGHT_LIMIT = 1024;
  localparam int ROW_W        = 10;
  localparam int HGT_W        = 11;
  localparam int POOL_REG_W   = 4;
  localparam int DIM_REG_W    = 11;
  localparam int CFG_W        = 11;
  localparam int CFG_IDX_W    = 2;
  localparam int COORD_W      = 10;
  localparam int OFS_W        = 3;

  // Output queue
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = 2;
  localparam int FIFO_CNT_W = 3;

  // Register reset values
  localparam logic [POOL_REG_W-1:0] POOL_RESET   = 4'd2;
  localparam logic [DIM_REG_W-1:0]  WIDTH_RESET  = 11'd1024;
  localparam logic [DIM_REG_W-1:0]  HEIGHT_RESET = 11'd1024;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POOL_SIZE    = 2'd0,
    REG_PLANE_WIDTH  = 2'd1,
    REG_PLANE_HEIGHT = 2'd2
  } cfg_reg_t;

  // Window status of one sample
  typedef struct packed {
    logic active;  // sample falls inside a whole window
    logic seed;    // first sample of its window
    logic last;    // last sample of its window
    logic done;    // window is the last one of the plane
  } win_ctl_t;

endpackage

@@ sv/max_pool_2d_with_argmax_core.sv @@
// Streaming 2-D max pooling with argmax. Takes one sample per cycle while the result queue
// has room, in raster order, plane after plane; emits one request per completed pool_size
// x pool_size window carrying the maximum, its output coordinates and the row/column
// offset of the maximum in the window (first maximum wins on ties). The sustained rate is
// one sample per clock, set by the band memory, which holds the running maximum of each
// output column of the current row band and is read once and written once per cycle; a
// result queue of four entries lets input keep flowing while results wait at the output.
// Registers must be written only while idle; the block does not enforce this.
module max_pool_2d_with_argmax_core #(
  parameter int MAX_WIDTH   = mp2d_pkg::MAX_WIDTH_DEF,
  parameter int MAX_POOL    = mp2d_pkg::MAX_POOL_DEF,
  parameter int SAMPLE_BITS = mp2d_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [mp2d_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mp2d_pkg::CFG_W-1:0]          cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [SAMPLE_BITS-1:0]       sample,
  input  logic                                plane_start,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [SAMPLE_BITS-1:0]       pooled,
  output logic [mp2d_pkg::COORD_W-1:0]        out_col,
  output logic [mp2d_pkg::COORD_W-1:0]        out_row,
  output logic [mp2d_pkg::OFS_W-1:0]          max_row_offset,
  output logic [mp2d_pkg::OFS_W-1:0]          max_col_offset,
  output logic                                plane_done
);
  import mp2d_pkg::*;

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int PHW   = $clog2(MAX_POOL);
  localparam int RAM_W = SAMPLE_BITS + 2 * PHW;
  localparam int RES_W = SAMPLE_BITS + 2 * COORD_W + 2 * OFS_W + 1;

  logic [POOL_REG_W-1:0] pool_size;
  logic [DIM_REG_W-1:0]  plane_width, plane_height;

  logic                  accept;
  logic [CW-1:0]         scan_addr;
  logic [ROW_W-1:0]      scan_row;
  logic [PHW-1:0]        scan_rph, scan_cph;
  win_ctl_t              scan_ctl;

  logic                  ram_we;
  logic [CW-1:0]         ram_waddr;
  logic [RAM_W-1:0]      ram_wdata, ram_rdata;

  logic                          push, pop;
  logic signed [SAMPLE_BITS-1:0] res_pooled;
  logic [COORD_W-1:0]            res_col, res_row;
  logic [OFS_W-1:0]              res_row_ofs, res_col_ofs;
  logic                          res_done;
  logic [RES_W-1:0]              fifo_data;
  logic [FIFO_CNT_W-1:0]         fifo_count;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      pool_size    <= POOL_RESET;
      plane_width  <= WIDTH_RESET;
      plane_height <= HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_POOL_SIZE:    pool_size    <= POOL_REG_W'(cfg_data);
        REG_PLANE_WIDTH:  plane_width  <= DIM_REG_W'(cfg_data);
        REG_PLANE_HEIGHT: plane_height <= DIM_REG_W'(cfg_data);
        default: ;
      endcase
    end
  end

  // Take a request only when the queue can absorb every result in flight
  assign in_ready = (fifo_count + FIFO_CNT_W'(push)) < FIFO_CNT_W'(FIFO_DEPTH);
  assign accept   = in_valid && in_ready;
  assign pop      = out_valid && out_ready;

  mp2d_scan #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_POOL  (MAX_POOL)
  ) u_scan (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .plane_start   (plane_start),
    .pool_size     (pool_size),
    .plane_width   (plane_width),
    .plane_height  (plane_height),
    .addr          (scan_addr),
    .out_row       (scan_row),
    .row_phase_out (scan_rph),
    .col_phase_out (scan_cph),
    .ctl           (scan_ctl)
  );

  mp2d_ram #(
    .WIDTH (RAM_W),
    .DEPTH (MAX_WIDTH)
  ) u_band_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (scan_addr),
    .rdata (ram_rdata)
  );

  mp2d_update #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .MAX_WIDTH   (MAX_WIDTH),
    .MAX_POOL    (MAX_POOL)
  ) u_update (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .sample      (sample),
    .addr        (scan_addr),
    .out_row     (scan_row),
    .row_phase   (scan_rph),
    .col_phase   (scan_cph),
    .ctl         (scan_ctl),
    .ram_rdata   (ram_rdata),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .push        (push),
    .res_pooled  (res_pooled),
    .res_col     (res_col),
    .res_row     (res_row),
    .res_row_ofs (res_row_ofs),
    .res_col_ofs (res_col_ofs),
    .res_done    (res_done)
  );

  mp2d_fifo #(
    .WIDTH (RES_W)
  ) u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({res_pooled, res_col, res_row, res_row_ofs, res_col_ofs, res_done}),
    .pop       (pop),
    .valid     (out_valid),
    .data      (fifo_data),
    .count     (fifo_count)
  );

  // Unpack the head of the queue
  assign {pooled, out_col, out_row, max_row_offset, max_col_offset, plane_done} = fifo_data;

  // Queue never overflows
  assert property (@(posedge clk) disable iff (rst)
    !(push && !pop && (fifo_count == FIFO_CNT_W'(FIFO_DEPTH))))
    else $error("result queue overflow");

  // Back-pressure only when the queue is nearly full
  assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (fifo_count >= FIFO_CNT_W'(FIFO_DEPTH - 1)))
    else $error("input stalled with room in the result queue");

  // A popped result leaves room for one more accepted request
  assert property (@(posedge clk) disable iff (rst)
    (pop && !push) |=> in_ready)
    else $error("input not ready after a result was taken");

endmodule

@@ sv/mp2d_ram.sv @@
module mp2d_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/mp2d_scan.sv @@
module mp2d_scan #(
  parameter int MAX_WIDTH = mp2d_pkg::MAX_WIDTH_DEF,
  parameter int MAX_POOL  = mp2d_pkg::MAX_POOL_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                accept,
  input  logic                                plane_start,
  input  logic [mp2d_pkg::POOL_REG_W-1:0]     pool_size,
  input  logic [mp2d_pkg::DIM_REG_W-1:0]      plane_width,
  input  logic [mp2d_pkg::DIM_REG_W-1:0]      plane_height,
  output logic [$clog2(MAX_WIDTH)-1:0]        addr,
  output logic [mp2d_pkg::ROW_W-1:0]          out_row,
  output logic [$clog2(MAX_POOL)-1:0]         row_phase_out,
  output logic [$clog2(MAX_POOL)-1:0]         col_phase_out,
  output mp2d_pkg::win_ctl_t                  ctl
);
  import mp2d_pkg::*;

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int WW  = CW + 1;
  localparam int PW  = $clog2(MAX_POOL + 1);
  localparam int PHW = $clog2(MAX_POOL);
  localparam int MCW = CW + 1 + PW;
  localparam int MRW = ROW_W + 1 + PW;

  logic [CW-1:0]    col_pos, out_col_pos;
  logic [ROW_W-1:0] row_pos, out_row_pos;
  logic [PHW-1:0]   col_phase, row_phase;

  logic [CW-1:0]    col_pos_next, out_col_pos_next;
  logic [ROW_W-1:0] row_pos_next, out_row_pos_next;
  logic [PHW-1:0]   col_phase_next, row_phase_next;

  logic [CW-1:0]    cp_e, ocp_e;
  logic [ROW_W-1:0] rp_e, orp_e;
  logic [PHW-1:0]   cph_e, rph_e;

  logic [PW-1:0]    p;
  logic [WW-1:0]    w;
  logic [HGT_W-1:0] h;

  logic [MCW-1:0]   col_end;
  logic [MRW-1:0]   row_end;
  logic             col_fit, row_fit, col_last, row_last;
  logic [PW-1:0]    cph_inc, rph_inc;
  logic [WW-1:0]    cp_inc;
  logic [ROW_W:0]   rp_inc;

  // Clamp the registers to their legal ranges
  always_comb begin
    if (pool_size == '0) begin
      p = PW'(1);
    end else if (32'(pool_size) > MAX_POOL) begin
      p = PW'(MAX_POOL);
    end else begin
      p = PW'(pool_size);
    end
    if (plane_width == '0) begin
      w = WW'(1);
    end else if (32'(plane_width) > MAX_WIDTH) begin
      w = WW'(MAX_WIDTH);
    end else begin
      w = WW'(plane_width);
    end
    if (plane_height == '0) begin
      h = HGT_W'(1);
    end else if (32'(plane_height) > HEIGHT_LIMIT) begin
      h = HGT_W'(HEIGHT_LIMIT);
    end else begin
      h = plane_height;
    end
  end

  // Restart all positions on a plane start
  always_comb begin
    cp_e  = plane_start ? '0 : col_pos;
    ocp_e = plane_start ? '0 : out_col_pos;
    rp_e  = plane_start ? '0 : row_pos;
    orp_e = plane_start ? '0 : out_row_pos;
    cph_e = plane_start ? '0 : col_phase;
    rph_e = plane_start ? '0 : row_phase;
  end

  // Classify the sample against the whole-window grid
  always_comb begin
    col_end  = (MCW'(ocp_e) + MCW'(1)) * MCW'(p);
    row_end  = (MRW'(orp_e) + MRW'(1)) * MRW'(p);
    col_fit  = col_end <= MCW'(w);
    row_fit  = row_end <= MRW'(h);
    col_last = (col_end + MCW'(p)) > MCW'(w);
    row_last = (row_end + MRW'(p)) > MRW'(h);

    ctl.active = col_fit && row_fit && (PW'(cph_e) < p) && (PW'(rph_e) < p);
    ctl.seed   = (cph_e == '0) && (rph_e == '0);
    ctl.last   = (PW'(cph_e) + PW'(1) == p) && (PW'(rph_e) + PW'(1) == p);
    ctl.done   = col_last && row_last;

    addr          = ocp_e;
    out_row       = orp_e;
    row_phase_out = rph_e;
    col_phase_out = cph_e;
  end

  // Advance the raster position
  always_comb begin
    cph_inc = PW'(cph_e) + PW'(1);
    rph_inc = PW'(rph_e) + PW'(1);
    cp_inc  = WW'(cp_e) + WW'(1);
    rp_inc  = {1'b0, rp_e} + (ROW_W + 1)'(1);

    col_pos_next     = CW'(cp_inc);
    row_pos_next     = rp_e;
    row_phase_next   = rph_e;
    out_row_pos_next = orp_e;
    if (cph_inc >= p) begin
      col_phase_next   = '0;
      out_col_pos_next = ocp_e + CW'(1);
    end else begin
      col_phase_next   = PHW'(cph_inc);
      out_col_pos_next = ocp_e;
    end

    if (cp_inc >= w) begin
      col_pos_next     = '0;
      col_phase_next   = '0;
      out_col_pos_next = '0;
      if (rph_inc >= p) begin
        row_phase_next   = '0;
        out_row_pos_next = orp_e + ROW_W'(1);
      end else begin
        row_phase_next = PHW'(rph_inc);
      end
      row_pos_next = ROW_W'(rp_inc);
      if (rp_inc >= (ROW_W + 1)'(h)) begin
        row_pos_next     = '0;
        row_phase_next   = '0;
        out_row_pos_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_pos     <= '0;
      row_pos     <= '0;
      col_phase   <= '0;
      row_phase   <= '0;
      out_col_pos <= '0;
      out_row_pos <= '0;
    end else if (accept) begin
      col_pos     <= col_pos_next;
      row_pos     <= row_pos_next;
      col_phase   <= col_phase_next;
      row_phase   <= row_phase_next;
      out_col_pos <= out_col_pos_next;
      out_row_pos <= out_row_pos_next;
    end
  end

endmodule

@@ sv/mp2d_update.sv @@
module mp2d_update #(
  parameter int SAMPLE_BITS = mp2d_pkg::SAMPLE_BITS_DEF,
  parameter int MAX_WIDTH   = mp2d_pkg::MAX_WIDTH_DEF,
  parameter int MAX_POOL    = mp2d_pkg::MAX_POOL_DEF
) (
  input  logic                                                clk,
  input  logic                                                rst,
  input  logic                                                accept,
  input  logic signed [SAMPLE_BITS-1:0]                       sample,
  input  logic [$clog2(MAX_WIDTH)-1:0]                        addr,
  input  logic [mp2d_pkg::ROW_W-1:0]                          out_row,
  input  logic [$clog2(MAX_POOL)-1:0]                         row_phase,
  input  logic [$clog2(MAX_POOL)-1:0]                         col_phase,
  input  mp2d_pkg::win_ctl_t                                  ctl,
  input  logic [SAMPLE_BITS+2*$clog2(MAX_POOL)-1:0]           ram_rdata,
  output logic                                                ram_we,
  output logic [$clog2(MAX_WIDTH)-1:0]                        ram_waddr,
  output logic [SAMPLE_BITS+2*$clog2(MAX_POOL)-1:0]           ram_wdata,
  output logic                                                push,
  output logic signed [SAMPLE_BITS-1:0]                       res_pooled,
  output logic [mp2d_pkg::COORD_W-1:0]                        res_col,
  output logic [mp2d_pkg::COORD_W-1:0]                        res_row,
  output logic [mp2d_pkg::OFS_W-1:0]                          res_row_ofs,
  output logic [mp2d_pkg::OFS_W-1:0]                          res_col_ofs,
  output logic                                                res_done
);
  import mp2d_pkg::*;

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int PHW   = $clog2(MAX_POOL);
  localparam int RAM_W = SAMPLE_BITS + 2 * PHW;

  // Stage registers
  logic                          s1_valid;
  win_ctl_t                      s1_ctl;
  logic signed [SAMPLE_BITS-1:0] s1_sample;
  logic [CW-1:0]                 s1_addr;
  logic [ROW_W-1:0]              s1_row;
  logic [PHW-1:0]                s1_rph, s1_cph;

  // Last band write, for a read issued in the same cycle
  logic                          fwd_valid;
  logic [CW-1:0]                 fwd_addr;
  logic [RAM_W-1:0]              fwd_data;

  logic [RAM_W-1:0]              old_entry, new_entry;
  logic signed [SAMPLE_BITS-1:0] old_max, new_max;
  logic [PHW-1:0]                new_rph, new_cph;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept && ctl.active;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ctl    <= ctl;
      s1_sample <= sample;
      s1_addr   <= addr;
      s1_row    <= out_row;
      s1_rph    <= row_phase;
      s1_cph    <= col_phase;
    end
  end

  // Pick the freshest copy of the band entry, then compare
  always_comb begin
    old_entry = (fwd_valid && (fwd_addr == s1_addr)) ? fwd_data : ram_rdata;
    old_max   = old_entry[RAM_W-1 -: SAMPLE_BITS];
    if (s1_ctl.seed) begin
      new_entry = {s1_sample, {(2 * PHW){1'b0}}};
    end else if (s1_sample > old_max) begin
      new_entry = {s1_sample, s1_rph, s1_cph};
    end else begin
      new_entry = old_entry;
    end
    new_max = new_entry[RAM_W-1 -: SAMPLE_BITS];
    new_rph = new_entry[2*PHW-1 -: PHW];
    new_cph = new_entry[PHW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else if (s1_valid) begin
      fwd_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      fwd_addr <= s1_addr;
      fwd_data <= new_entry;
    end
  end

  // Write back and hand off a completed window
  always_comb begin
    ram_we      = s1_valid;
    ram_waddr   = s1_addr;
    ram_wdata   = new_entry;
    push        = s1_valid && s1_ctl.last;
    res_pooled  = new_max;
    res_col     = COORD_W'(s1_addr);
    res_row     = COORD_W'(s1_row);
    res_row_ofs = OFS_W'(new_rph);
    res_col_ofs = OFS_W'(new_cph);
    res_done    = s1_ctl.done;
  end

endmodule

@@ sv/mp2d_fifo.sv @@
module mp2d_fifo #(
  parameter int WIDTH = 43
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  input  logic [WIDTH-1:0]                push_data,
  input  logic                            pop,
  output logic                            valid,
  output logic [WIDTH-1:0]                data,
  output logic [mp2d_pkg::FIFO_CNT_W-1:0] count
);
  import mp2d_pkg::*;

  logic [WIDTH-1:0]      mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr, rd_ptr;

  assign valid = count != '0;
  assign data  = mem[rd_ptr];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + FIFO_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_PTR_W'(1);
      end
      count <= count + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule
